FILE: design/bbc_pkg.sv
// Shared types and codes for the block buffer cache tag store.
// No dependencies; the interfaces and the core import this package.
package bbc_pkg;

    localparam int REF_W = 6;
    localparam logic [REF_W-1:0] COUNT_MAX = 6'd63;

    localparam logic [1:0] FUNC_GET = 2'd0;
    localparam logic [1:0] FUNC_REL = 2'd1;
    localparam logic [1:0] FUNC_UPD = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_MISS   = 2'd1;
    localparam logic [1:0] STAT_NOFREE = 2'd2;
    localparam logic [1:0] STAT_UNREF  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  device;
        logic [23:0] block_number;
        logic [4:0]  slot;
        logic        new_valid;
        logic        new_dirty;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [4:0]       result_slot;
        logic             needs_read;
        logic [REF_W-1:0] references;
    } rsp_t;

endpackage

FILE: design/bbc_req_if.sv
// Request channel: valid/ready handshake carrying one req_t beat.
// Depends on bbc_pkg.
interface bbc_req_if
    import bbc_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/bbc_rsp_if.sv
// Response channel: valid/ready handshake carrying one rsp_t beat.
// Depends on bbc_pkg.
interface bbc_rsp_if
    import bbc_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/bbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/block_buffer_cache_lru_core.sv
// Block buffer cache tag store: all slot state in one RAM, scanned one entry a cycle.
// Get: a full scan before the result. Release: a rank shift pass when the count
// drops to zero. One request at a time; the RAM's single read port sets the scan
// length. After reset a clearing pass writes initial tags and ranks; no request is
// taken during it.
// Depends on bbc_pkg, bbc_req_if, bbc_rsp_if and bbc_ram.
module block_buffer_cache_lru_core
    import bbc_pkg::*;
#(
    parameter int NUM_BUFFERS = 32,
    parameter int BLOCK_BITS  = 24,
    parameter int DEVICE_BITS = 8
) (
    input logic       clk,
    input logic       rst_n,
    bbc_req_if.sink   req,
    bbc_rsp_if.source rsp
);
    localparam int AW = $clog2(NUM_BUFFERS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BUFFERS - 1);
    localparam logic [AW:0]   SCAN_END = (AW+1)'(NUM_BUFFERS);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_GSCAN = 3'd2;
    localparam logic [2:0] S_GEND  = 3'd3;
    localparam logic [2:0] S_RREAD = 3'd4;
    localparam logic [2:0] S_RSCAN = 3'd5;
    localparam logic [2:0] S_UREAD = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    typedef struct packed {
        logic [DEVICE_BITS-1:0] dev;
        logic [BLOCK_BITS-1:0]  blk;
        logic [REF_W-1:0]       refs;
        logic                   valid;
        logic                   dirty;
        logic [AW-1:0]          rank;
    } entry_t;

    logic [2:0] state_reg, state_next;
    logic [AW:0] scan_reg, scan_next;
    logic pend_reg, pend_next;
    logic [AW-1:0] pidx_reg, pidx_next;
    req_t req_reg, req_next;
    logic hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    entry_t hit_ent_reg, hit_ent_next;
    logic fr_reg, fr_next;
    logic [AW-1:0] fr_idx_reg, fr_idx_next;
    entry_t fr_ent_reg, fr_ent_next;
    logic [AW-1:0] rank_reg, rank_next;
    rsp_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg, out_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, rd_ent;

    logic [DEVICE_BITS-1:0] dev_key;
    logic [BLOCK_BITS-1:0]  blk_key;
    logic [AW-1:0]          slot_idx;
    logic                   slot_ok;
    logic                   is_match, is_free;
    rsp_t                   echo_rsp;

    bbc_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUM_BUFFERS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_ent)
    );

    assign dev_key  = DEVICE_BITS'(req_reg.device);
    assign blk_key  = BLOCK_BITS'(req_reg.block_number);
    assign slot_idx = AW'(req_reg.slot);
    assign is_match = (rd_ent.dev == dev_key) && (rd_ent.blk == blk_key);
    assign is_free  = (rd_ent.refs == '0) && !rd_ent.dirty;
    assign slot_ok  = 32'(req.data.slot) < NUM_BUFFERS;
    assign echo_rsp = '{status: STAT_OK, result_slot: req.data.slot,
                        needs_read: 1'b0, references: '0};

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pidx_next      = scan_reg[AW-1:0];
        req_next       = req_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_ent_next   = hit_ent_reg;
        fr_next        = fr_reg;
        fr_idx_next    = fr_idx_reg;
        fr_ent_next    = fr_ent_reg;
        rank_next      = rank_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = pidx_reg;
        ram_wdata      = rd_ent;
        ram_raddr      = scan_reg[AW-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // issue one scan read a cycle; data comes back with pend_reg set
        if ((state_reg == S_GSCAN || state_reg == S_RSCAN) && scan_reg != SCAN_END)
        begin
            pend_next = 1'b1;
            scan_next = scan_reg + 1'b1;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[AW-1:0];
                ram_wdata = '{dev: '0, blk: '0, refs: '0, valid: 1'b0, dirty: 1'b0,
                              rank: LAST_IDX - scan_reg[AW-1:0]};
                scan_next = scan_reg + 1'b1;
                if (scan_reg[AW-1:0] == LAST_IDX)
                begin
                    scan_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = AW'(req.data.slot);
                if (req.valid)
                begin
                    req_next  = req.data;
                    hit_next  = 1'b0;
                    fr_next   = 1'b0;
                    scan_next = '0;
                    res_next  = echo_rsp;
                    case (req.data.func)
                        FUNC_GET: state_next = S_GSCAN;
                        FUNC_REL: state_next = slot_ok ? S_RREAD : S_DONE;
                        FUNC_UPD: state_next = slot_ok ? S_UREAD : S_DONE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_GSCAN:
            begin
                if (pend_reg)
                begin
                    // keep most recent match and least recent free slot
                    if (is_match && (!hit_reg || rd_ent.rank < hit_ent_reg.rank))
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = pidx_reg;
                        hit_ent_next = rd_ent;
                    end
                    if (is_free && (!fr_reg || rd_ent.rank > fr_ent_reg.rank))
                    begin
                        fr_next     = 1'b1;
                        fr_idx_next = pidx_reg;
                        fr_ent_next = rd_ent;
                    end
                    if (pidx_reg == LAST_IDX)
                    begin
                        state_next = S_GEND;
                    end
                end
            end
            S_GEND:
            begin
                state_next = S_DONE;
                if (hit_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = hit_idx_reg;
                    ram_wdata = hit_ent_reg;
                    if (hit_ent_reg.refs != COUNT_MAX)
                    begin
                        ram_wdata.refs = hit_ent_reg.refs + 1'b1;
                    end
                    res_next = '{status: STAT_OK, result_slot: 5'(hit_idx_reg),
                                 needs_read: !hit_ent_reg.valid,
                                 references: ram_wdata.refs};
                end
                else if (fr_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = fr_idx_reg;
                    ram_wdata = '{dev: dev_key, blk: blk_key, refs: REF_W'(1), valid: 1'b0,
                                  dirty: 1'b0, rank: fr_ent_reg.rank};
                    res_next  = '{status: STAT_MISS, result_slot: 5'(fr_idx_reg),
                                  needs_read: 1'b1, references: REF_W'(1)};
                end
                else
                begin
                    res_next = '{status: STAT_NOFREE, result_slot: '0,
                                 needs_read: 1'b0, references: '0};
                end
            end
            S_RREAD:
            begin
                state_next = S_DONE;
                if (rd_ent.refs == '0)
                begin
                    res_next.status = STAT_UNREF;
                end
                else if (rd_ent.refs != REF_W'(1))
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = slot_idx;
                    ram_wdata.refs = rd_ent.refs - 1'b1;
                    res_next.references = ram_wdata.refs;
                end
                else
                begin
                    // count drops to zero: age everything newer, then promote
                    rank_next  = rd_ent.rank;
                    scan_next  = '0;
                    state_next = S_RSCAN;
                end
            end
            S_RSCAN:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                    if (pidx_reg == slot_idx)
                    begin
                        ram_wdata.refs = '0;
                        ram_wdata.rank = '0;
                    end
                    else if (rd_ent.rank < rank_reg)
                    begin
                        ram_wdata.rank = rd_ent.rank + 1'b1;
                    end
                    if (pidx_reg == LAST_IDX)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_UREAD:
            begin
                ram_we          = 1'b1;
                ram_waddr       = slot_idx;
                ram_wdata.valid = req_reg.new_valid;
                ram_wdata.dirty = req_reg.new_dirty;
                res_next.references = rd_ent.refs;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg    <= pidx_next;
        req_reg     <= req_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        hit_ent_reg <= hit_ent_next;
        fr_reg      <= fr_next;
        fr_idx_reg  <= fr_idx_next;
        fr_ent_reg  <= fr_ent_next;
        rank_reg    <= rank_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    a_miss_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == STAT_MISS)
            |-> (rsp.data.needs_read && rsp.data.references == REF_W'(1)))
        else $error("miss beat without read request or count one");

    a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == STAT_NOFREE)
            |-> (rsp.data.references == '0 && rsp.data.result_slot == '0
                 && !rsp.data.needs_read))
        else $error("no-free beat carries nonzero fields");

    a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> !(req.valid && req.ready))
        else $error("request accepted during clearing pass");

    a_rscan_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RSCAN && ram_we && ram_waddr == slot_idx)
            |-> (ram_wdata.rank == '0 && ram_wdata.refs == '0))
        else $error("released slot not promoted to most recent");
endmodule
